[src/spectral_bin_beat_detector_unit_assert.svh]
// Assertion macros for the spectral bin beat detector.
`ifndef SPECTRAL_BIN_BEAT_DETECTOR_UNIT_ASSERT_SVH
`define SPECTRAL_BIN_BEAT_DETECTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property at every rising clock edge outside reset.
`define SBBD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sbbd: assertion failed");
// Check that a condition in one cycle implies another in the next cycle.
`define SBBD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbbd: assertion failed");
`else
`define SBBD_ASSERT(lbl, clk, rst, prop)
`define SBBD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/sbbd_pkg.sv]
// Package: widths, reset values, register codes and shared types of the beat detector.
`timescale 1ns / 1ps
package sbbd_pkg;

   localparam int BINS_DEFAULT = 256;

   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = SAMPLE_W + 1;
   localparam int ENERGY_W    = 2 * SUM_W - 1;      // magnitude squared, at most 2^32
   localparam int FRAC_W      = 8;                  // fraction bits of the average
   localparam int AVG_W       = 48;                 // stored average width
   localparam int QUOT_W      = ENERGY_W + FRAC_W;  // average never exceeds 2^40
   localparam int WINDOW_W    = 11;
   localparam int RATIO_W     = 8;
   localparam int NUM_W       = QUOT_W + WINDOW_W;  // dividend width
   localparam int BEAT_W      = QUOT_W + RATIO_W;   // ratio times average
   localparam int MUL_B_W     = SUM_W;
   localparam int MUL_W       = AVG_W + MUL_B_W;
   localparam int BIN_INDEX_W = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = WINDOW_W;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(8);
   localparam logic [RATIO_W-1:0]  RATIO_RESET  = RATIO_W'(9);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_AVERAGE_WINDOW = 8'd0,
      CSR_BEAT_RATIO     = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sbbd_div_status_type;

endpackage

[src/sbbd_if.sv]
// Channel interfaces: input word, result word and register write.
`timescale 1ns / 1ps
interface sbbd_req_if import sbbd_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_value;
   logic signed [SAMPLE_W-1:0] right_value;
   modport source (output valid, output left_value, output right_value, input ready);
   modport sink (input valid, input left_value, input right_value, output ready);
endinterface

interface sbbd_rsp_if import sbbd_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [BIN_INDEX_W-1:0] bin_index;
   logic                   bin_beat;
   logic                   frame_end;
   modport source (output valid, output bin_index, output bin_beat, output frame_end,
                   input ready);
   modport sink (input valid, input bin_index, input bin_beat, input frame_end,
                 output ready);
endinterface

interface sbbd_csr_if import sbbd_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[src/spectral_bin_beat_detector_unit.sv]
// Top level: per-bin energy average and beat flag, one spectrum bin per input word.
//
// Usage:
//   req_if  takes one word per spectrum bin (left_value, right_value), bins in order
//           0 to BINS-1; an internal counter tracks the bin and wraps.
//   rsp_if  returns one word per input word: bin_index (low 8 bits of the bin),
//           bin_beat and frame_end (set on bin BINS-1).
//   csr_if  writes average_window (index 0) and beat_ratio (index 1); always ready.
//           Write only while no word is in flight.
// Sequence: a word is accepted only in the idle state, so the next word waits until the
//   result of the last one is in the output register. Steps in order: the square, the
//   scale by N-1, the dividend load, the 41-step restoring divider (one quotient bit a
//   cycle), the average write and the beat compare; the square, the scale and the
//   ratio times the new average share one 48x17 multiplier.
// Reset: synchronous, active high. Counter to bin 0, window 8, ratio 9. The average
//   store is not swept: during the first frame after reset every bin reads as zero,
//   since each bin is written in order before it is read again.
// Stall: the result waits in an output register; if rsp_if.ready stays low the unit
//   holds the next finished result in its compare step and keeps req_if.ready low.
`timescale 1ns / 1ps
`include "spectral_bin_beat_detector_unit_assert.svh"
module spectral_bin_beat_detector_unit import sbbd_pkg::*; #(
   parameter int BINS = BINS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   sbbd_req_if.sink   req_if,
   sbbd_rsp_if.source rsp_if,
   sbbd_csr_if.sink   csr_if
);

   localparam int CNT_W = $clog2(BINS);
   localparam logic [CNT_W-1:0] LAST_BIN = CNT_W'(BINS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_SCALE,
      S_LOAD,
      S_DIV,
      S_WRITE,
      S_TEST
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   first_pass_ff, first_pass_in;
   logic [WINDOW_W-1:0]    window_ff, window_in;
   logic [RATIO_W-1:0]     ratio_ff, ratio_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BIN_INDEX_W-1:0] bin_index_ff, bin_index_in;
   logic                   beat_ff, beat_in;
   logic                   frame_end_ff, frame_end_in;

   logic [SUM_W-1:0]       mag_ff, mag_in;
   logic [ENERGY_W-1:0]    energy_ff, energy_in;
   logic [MUL_W-1:0]       prod_ff, prod_in;
   logic [AVG_W-1:0]       avg_rd_ff;

   logic [AVG_W-1:0]       avg_mem [BINS];

   logic                   accept;
   logic                   out_free;
   logic signed [SUM_W-1:0] sum;
   logic [WINDOW_W-1:0]    window_n;
   logic [AVG_W-1:0]       avg_cur;
   logic [AVG_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [MUL_W-1:0]       mul_p;
   logic [QUOT_W-1:0]      energy_q;
   logic [NUM_W-1:0]       div_num;
   logic                   div_start;
   logic [QUOT_W-1:0]      quotient;
   sbbd_div_status_type    div_status;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Channel sum and its magnitude; -65536 still fits as an unsigned 17-bit value.
   assign sum = SUM_W'(req_if.left_value) + SUM_W'(req_if.right_value);

   // A window of zero behaves as one.
   assign window_n = (window_ff == '0) ? WINDOW_W'(1) : window_ff;

   // Bins not yet written since reset read as zero.
   assign avg_cur = first_pass_ff ? '0 : avg_rd_ff;

   // Energy in average units (8 fraction bits).
   assign energy_q = {energy_ff, {FRAC_W{1'b0}}};
   assign div_num  = prod_ff[NUM_W-1:0] + NUM_W'(energy_q);
   assign div_start = (state_ff == S_LOAD);

   // Shared multiplier: square, scale of the old average, ratio times the new average.
   always_comb begin
      case (state_ff)
         S_SQUARE: begin
            mul_a = AVG_W'(mag_ff);
            mul_b = mag_ff;
         end
         S_SCALE: begin
            mul_a = avg_cur;
            mul_b = MUL_B_W'(window_n - WINDOW_W'(1));
         end
         S_WRITE: begin
            mul_a = AVG_W'(quotient);
            mul_b = MUL_B_W'(ratio_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   sbbd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (div_num),
      .divisor   (window_n),
      .quotient  (quotient),
      .status    (div_status)
   );

   // Sequencer and register writes.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      first_pass_in = first_pass_ff;
      window_in     = window_ff;
      ratio_in      = ratio_ff;
      rsp_valid_in  = rsp_valid_ff;
      bin_index_in  = bin_index_ff;
      beat_in       = beat_ff;
      frame_end_in  = frame_end_ff;
      mag_in        = mag_ff;
      energy_in     = energy_ff;
      prod_in       = prod_ff;

      // Drop the result word once taken.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_AVERAGE_WINDOW: window_in = csr_if.data;
            CSR_BEAT_RATIO:     ratio_in  = csr_if.data[RATIO_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mag_in   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            prod_in  = mul_p;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            energy_in = prod_ff[ENERGY_W-1:0];
            prod_in   = mul_p;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            prod_in  = mul_p;
            state_in = S_TEST;
         end
         S_TEST: begin
            // Hold here until the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               bin_index_in = BIN_INDEX_W'(cnt_ff);
               beat_in      = BEAT_W'(energy_q) > prod_ff[BEAT_W-1:0];
               frame_end_in = (cnt_ff == LAST_BIN);
               if (cnt_ff == LAST_BIN) begin
                  cnt_in        = '0;
                  first_pass_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         first_pass_ff <= 1'b1;
         window_ff     <= WINDOW_RESET;
         ratio_ff      <= RATIO_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         first_pass_ff <= first_pass_in;
         window_ff     <= window_in;
         ratio_ff      <= ratio_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      bin_index_ff <= bin_index_in;
      beat_ff      <= beat_in;
      frame_end_ff <= frame_end_in;
      mag_ff       <= mag_in;
      energy_ff    <= energy_in;
      prod_ff      <= prod_in;
   end

   // Average store: read the bin on accept, write the new average after the divide.
   always_ff @(posedge clock) begin
      if (accept) begin
         avg_rd_ff <= avg_mem[cnt_ff];
      end
      if (state_ff == S_WRITE) begin
         avg_mem[cnt_ff] <= AVG_W'(quotient);
      end
   end

   assign req_if.ready     = (state_ff == S_IDLE);
   assign csr_if.ready     = 1'b1;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.bin_index = bin_index_ff;
   assign rsp_if.bin_beat  = beat_ff;
   assign rsp_if.frame_end = frame_end_ff;

   `SBBD_ASSERT_NEXT(a_req_blocks, clock, reset, req_if.valid && req_if.ready, !req_if.ready)
   `SBBD_ASSERT(a_div_idle, clock, reset, (state_ff == S_IDLE) |-> !div_status.busy)
   `SBBD_ASSERT(a_div_range, clock, reset, div_start |-> (div_num[NUM_W-1:QUOT_W] < window_n))
   `SBBD_ASSERT(a_frame_index, clock, reset, (rsp_if.valid && rsp_if.frame_end) |-> (rsp_if.bin_index == BIN_INDEX_W'(BINS - 1)))

endmodule

[src/sbbd_divider.sv]
// Restoring divider: one quotient bit per cycle, quotient known to fit QUOT_W bits.
`timescale 1ns / 1ps
module sbbd_divider import sbbd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_W-1:0]    numerator,
   input  logic [WINDOW_W-1:0] divisor,
   output logic [QUOT_W-1:0]   quotient,
   output sbbd_div_status_type status
);

   localparam int STEP_W = $clog2(QUOT_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [WINDOW_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]   quo_ff, quo_in;
   logic [WINDOW_W:0]   trial;
   logic [WINDOW_W+1:0] diff;
   logic                fits;

   // Bring down the next dividend bit and try the subtract.
   assign trial = {rem_ff, quo_ff[QUOT_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor};
   assign fits  = ~diff[WINDOW_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(QUOT_W - 1);
         rem_in  = numerator[NUM_W-1:QUOT_W];
         quo_in  = numerator[QUOT_W-1:0];
      end else if (busy_ff) begin
         rem_in = fits ? diff[WINDOW_W-1:0] : trial[WINDOW_W-1:0];
         quo_in = {quo_ff[QUOT_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
